// ----- rtl/core/glos_pkg.sv -----
package glos_pkg;

  // default grid size
  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 32;

  // coordinate field widths
  localparam int X_W = 6;
  localparam int Y_W = 5;

  // stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  // beat kind carried on in_tuser
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // result of the shared step unit for one cell
  typedef struct packed {
    logic           at_end;    // cell is the target
    logic           off_grid;  // cell lies outside the grid
    logic [X_W-1:0] next_x;    // next cell toward the target
    logic [Y_W-1:0] next_y;
  } step_t;

endpackage

// ----- rtl/core/glos_ram.sv -----
module glos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/glos_step.sv -----
module glos_step #(
  parameter int GRID_WIDTH  = glos_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = glos_pkg::GRID_HEIGHT_DEF
) (
  input  logic [glos_pkg::X_W-1:0]                  cur_x,
  input  logic [glos_pkg::Y_W-1:0]                  cur_y,
  input  logic [glos_pkg::X_W-1:0]                  end_x,
  input  logic [glos_pkg::Y_W-1:0]                  end_y,
  output glos_pkg::step_t                           step,
  output logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0] addr
);

  localparam int ADDR_W = $clog2(GRID_WIDTH * GRID_HEIGHT);

  logic [glos_pkg::X_W-1:0] dx;
  logic [glos_pkg::X_W-1:0] dy_ext;
  logic [glos_pkg::Y_W-1:0] dy;
  logic                     mv_x;
  logic                     mv_y;

  assign dx     = (cur_x > end_x) ? cur_x - end_x : end_x - cur_x;
  assign dy     = (cur_y > end_y) ? cur_y - end_y : end_y - cur_y;
  assign dy_ext = glos_pkg::X_W'(dy);

  // larger distance wins; equal distances step diagonally
  assign mv_x = (dy == '0) || ((dx != '0) && (dx >= dy_ext));
  assign mv_y = (dx == '0) || ((dy != '0) && (dy_ext >= dx));

  always_comb begin
    step.at_end   = (cur_x == end_x) && (cur_y == end_y);
    step.off_grid = (int'(cur_x) >= GRID_WIDTH) || (int'(cur_y) >= GRID_HEIGHT);
    step.next_x   = cur_x;
    step.next_y   = cur_y;
    if (mv_x) begin
      step.next_x = (cur_x < end_x) ? cur_x + 1'b1 : cur_x - 1'b1;
    end
    if (mv_y) begin
      step.next_y = (cur_y < end_y) ? cur_y + 1'b1 : cur_y - 1'b1;
    end
  end

  // row-major cell address, meaningful only when on the grid
  assign addr = ADDR_W'(int'(cur_y) * GRID_WIDTH + int'(cur_x));

endmodule

// ----- rtl/core/grid_line_of_sight_top.sv -----
// Line-of-sight walker over a wall bitmap of GRID_WIDTH x GRID_HEIGHT cells.
// Input channel (in_*): one beat is a cell write (in_tuser = 0) or a sight
// query (in_tuser = 1). A write stores wall_bit at (start_x, start_y) and gives
// no result; cells off the grid are not stored.
// Output channel (out_*): one beat per query, out_tdata[0] = 1 when the end
// cell is reached before any wall, 0 when blocked.
// A query walks the cells in turn: ST_LOOK forms the cell address in the
// shared step unit and issues the read, ST_WAIT waits for the registered
// RAM read. out_tvalid rises once the walk reaches the end cell, meets a
// wall or leaves the grid; the single RAM read port sets the walk's pace.
// in_tready is low while a query walks and is back high in the cycle the
// answer appears.
// After reset the block clears the map one cell per cycle, all
// GRID_WIDTH*GRID_HEIGHT cells (2048 by default), with in_tready low.
// A finished answer sits in an output register; the block takes new beats
// while it waits. A second answer finishing before the first is taken
// holds in the walker until out_tready frees the register.
module grid_line_of_sight_top #(
  parameter int GRID_WIDTH  = glos_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = glos_pkg::GRID_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // start_x[5:0], start_y[10:6], end_x[16:11], end_y[21:17], wall_bit[22]
  input  logic [glos_pkg::IN_TDATA_W-1:0]     in_tdata,
  // action[0]
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // sight_clear[0]
  output logic [glos_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,  // post-reset map wipe
    ST_IDLE  = 5'b00010,  // take beats
    ST_LOOK  = 5'b00100,  // test end / off-grid, issue read
    ST_WAIT  = 5'b01000,  // read data back, test wall
    ST_DONE  = 5'b10000   // hand answer to output register
  } state_t;

  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [glos_pkg::X_W-1:0] cur_x_r, cur_x_nxt, end_x_r, end_x_nxt;
  logic [glos_pkg::Y_W-1:0] cur_y_r, cur_y_nxt, end_y_r, end_y_nxt;
  logic                     res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_clear_r, out_clear_nxt;

  // input fields
  logic [glos_pkg::X_W-1:0] in_start_x, in_end_x;
  logic [glos_pkg::Y_W-1:0] in_start_y, in_end_y;
  logic                     in_wall_bit;
  logic                     in_beat;

  assign in_start_x  = in_tdata[5:0];
  assign in_start_y  = in_tdata[10:6];
  assign in_end_x    = in_tdata[16:11];
  assign in_end_y    = in_tdata[21:17];
  assign in_wall_bit = in_tdata[22];

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  // shared step unit: input cell in IDLE, walk cell otherwise
  logic [glos_pkg::X_W-1:0] su_x;
  logic [glos_pkg::Y_W-1:0] su_y;
  glos_pkg::step_t          su_step;
  logic [ADDR_W-1:0]        su_addr;

  assign su_x = (state_r == ST_IDLE) ? in_start_x : cur_x_r;
  assign su_y = (state_r == ST_IDLE) ? in_start_y : cur_y_r;

  glos_step #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_step (
    .cur_x(su_x),
    .cur_y(su_y),
    .end_x(end_x_r),
    .end_y(end_y_r),
    .step (su_step),
    .addr (su_addr)
  );

  // wall map
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [0:0]        ram_wdata;
  logic [0:0]        ram_rdata;

  glos_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(su_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    end_x_nxt   = end_x_r;
    end_y_nxt   = end_y_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = su_addr;
    ram_wdata   = in_wall_bit;
    out_valid_nxt = out_valid_r && !out_tready;
    out_clear_nxt = out_clear_r;

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = 1'b0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          if (in_tuser[0] == glos_pkg::ACT_WRITE) begin
            ram_we = !su_step.off_grid;
          end else if (in_tuser[0] == glos_pkg::ACT_QUERY) begin
            cur_x_nxt = in_start_x;
            cur_y_nxt = in_start_y;
            end_x_nxt = in_end_x;
            end_y_nxt = in_end_y;
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (su_step.at_end) begin
          res_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (su_step.off_grid) begin
          res_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          // read of this cell is in flight; advance now, drop if wall
          cur_x_nxt = su_step.next_x;
          cur_y_nxt = su_step.next_y;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (ram_rdata[0]) begin
          res_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_LOOK;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_clear_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    end_x_r     <= end_x_nxt;
    end_y_r     <= end_y_nxt;
    res_r       <= res_nxt;
    out_clear_r <= out_clear_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(glos_pkg::OUT_TDATA_W - 1)'(0), out_clear_r};

  // no answer can appear while the map is still being wiped
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("output valid during map clear");

  // map is read-only during a walk
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK || state_r == ST_WAIT) |-> !ram_we)
    else $error("map write during walk");

  // an issued read is always followed by its data check
  a_read_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK && !su_step.at_end && !su_step.off_grid) |=>
      (state_r == ST_WAIT))
    else $error("read issued without wait");

  // a wall hit ends the walk as blocked
  a_wall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT && ram_rdata[0]) |=> (state_r == ST_DONE && !res_r))
    else $error("wall did not block");

endmodule
